@@ hdl/tsq_pkg.sv @@
// shared types and constants for the two-stack queue
package tsq_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int CMDQ_DEPTH  = 2;
   localparam int DATA_W      = 32;

   localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef struct packed {
      logic                     func;
      logic signed [DATA_W-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] popped_value;
      logic                     was_empty;
      logic                     mismatch;
      logic                     push_dropped;
   } rsp_type;

   typedef struct packed {
      op_type                   op;
      logic signed [DATA_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmdq_head_type;

endpackage

@@ hdl/two_stack_fifo_queue.sv @@
// top level of the first-in first-out queue built from two stacks
// a request is written into the command queue, taken by the back end and answered from the response register
// a pop that finds the output stack empty first moves every input entry across, then reads the output stack
// throughput: one push per cycle while the back end is idle; a pop holds the back end until its response is registered
// reset clears the counts and the command queue; stack contents are not cleared
// rsp_valid is a one-cycle strobe, the receiver cannot stall
module two_stack_fifo_queue #(
   parameter int STACK_DEPTH = tsq_pkg::STACK_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   // request transaction
   input  logic             start,
   output logic             busy,
   input  tsq_pkg::req_type req_data,
   // response transaction
   output logic             rsp_valid,
   output tsq_pkg::rsp_type rsp_data
);

   // head of the command queue between front and back
   tsq_pkg::cmdq_head_type cmdq_head;
   // back end takes the head command
   logic                   cmd_pop;

   // front: takes each transaction while not busy, decodes push or pop, queues it
   tsq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .cmdq_head (cmdq_head),
      .cmd_pop   (cmd_pop)
   );

   // back: stacks, refill sequencing, compare and response register
   tsq_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmdq_head (cmdq_head),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

@@ hdl/tsq_front.sv @@
// front end: accepts transactions, decodes the operation and queues commands
module tsq_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  tsq_pkg::req_type       req_data,
   output tsq_pkg::cmdq_head_type cmdq_head,
   input  logic                   cmd_pop
);

   localparam int PTR_W = $clog2(tsq_pkg::CMDQ_DEPTH);
   localparam int CNT_W = $clog2(tsq_pkg::CMDQ_DEPTH + 1);

   tsq_pkg::cmd_type        entry_ff [tsq_pkg::CMDQ_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    push;
   tsq_pkg::cmd_type        new_cmd;

   assign busy = (count_ff == CNT_W'(tsq_pkg::CMDQ_DEPTH));
   assign push = start && !busy;

   // decode the requested operation
   always_comb begin
      new_cmd.op    = req_data.func ? tsq_pkg::OP_POP : tsq_pkg::OP_PUSH;
      new_cmd.value = req_data.item_value;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(tsq_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(tsq_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign cmdq_head.valid = (count_ff != '0);
   assign cmdq_head.cmd   = entry_ff[rd_ptr_ff];

endmodule

@@ hdl/tsq_back.sv @@
// back end: the two stacks, the refill sequencer and the result register
module tsq_back #(
   parameter int STACK_DEPTH = tsq_pkg::STACK_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tsq_pkg::cmdq_head_type cmdq_head,
   output logic                   cmd_pop,
   output logic                   rsp_valid,
   output tsq_pkg::rsp_type       rsp_data
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MOVE,
      S_POP_READ,
      S_POP_WAIT
   } state_type;

   state_type                        state_ff, state_in;
   logic [CNT_W-1:0]                 in_count_ff, in_count_in;
   logic [CNT_W-1:0]                 out_count_ff, out_count_in;
   logic                             mv_pend_ff, mv_pend_in;
   tsq_pkg::cmd_type                 cmd_ff, cmd_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   tsq_pkg::rsp_type                 rsp_ff, rsp_in;

   logic signed [tsq_pkg::DATA_W-1:0] in_mem  [STACK_DEPTH];
   logic signed [tsq_pkg::DATA_W-1:0] out_mem [STACK_DEPTH];
   logic signed [tsq_pkg::DATA_W-1:0] in_rd_ff;
   logic signed [tsq_pkg::DATA_W-1:0] out_rd_ff;

   logic                             in_we, out_we;
   logic [ADDR_W-1:0]                in_waddr, in_raddr, out_waddr, out_raddr;
   logic signed [tsq_pkg::DATA_W-1:0] in_wdata;
   logic [CNT_W-1:0]                 in_top, out_top;

   assign in_top  = in_count_ff - 1'b1;
   assign out_top = out_count_ff - 1'b1;

   always_comb begin
      state_in     = state_ff;
      in_count_in  = in_count_ff;
      out_count_in = out_count_ff;
      mv_pend_in   = 1'b0;
      cmd_in       = cmd_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      in_we        = 1'b0;
      in_waddr     = in_count_ff[ADDR_W-1:0];
      in_wdata     = cmdq_head.cmd.value;
      in_raddr     = in_top[ADDR_W-1:0];
      out_we       = 1'b0;
      out_waddr    = out_count_ff[ADDR_W-1:0];
      out_raddr    = out_top[ADDR_W-1:0];
      case (state_ff)
         S_IDLE: begin
            if (cmdq_head.valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmdq_head.cmd;
               case (cmdq_head.cmd.op)
                  tsq_pkg::OP_PUSH: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                     if (in_count_ff == CNT_W'(STACK_DEPTH)) begin
                        rsp_in.push_dropped = 1'b1;
                     end else begin
                        in_we       = 1'b1;
                        in_count_in = in_count_ff + 1'b1;
                     end
                  end
                  tsq_pkg::OP_POP: begin
                     if (out_count_ff != '0) begin
                        out_count_in = out_top;
                        state_in     = S_POP_WAIT;
                     end else if (in_count_ff == '0) begin
                        rsp_valid_in          = 1'b1;
                        rsp_in.popped_value   = tsq_pkg::EMPTY_VALUE;
                        rsp_in.was_empty      = 1'b1;
                        rsp_in.mismatch       = (cmdq_head.cmd.value != tsq_pkg::EMPTY_VALUE);
                        rsp_in.push_dropped   = 1'b0;
                     end else begin
                        state_in = S_MOVE;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_MOVE: begin
            // read one input entry per cycle, write it across from the registered read data
            if (mv_pend_ff) begin
               out_we       = 1'b1;
               out_count_in = out_count_ff + 1'b1;
            end
            if (in_count_ff != '0) begin
               in_count_in = in_top;
               mv_pend_in  = 1'b1;
            end else if (!mv_pend_ff) begin
               state_in = S_POP_READ;
            end
         end
         S_POP_READ: begin
            out_count_in = out_top;
            state_in     = S_POP_WAIT;
         end
         S_POP_WAIT: begin
            rsp_valid_in        = 1'b1;
            rsp_in.popped_value = out_rd_ff;
            rsp_in.was_empty    = 1'b0;
            rsp_in.mismatch     = (out_rd_ff != cmd_ff.value);
            rsp_in.push_dropped = 1'b0;
            state_in            = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_count_ff  <= '0;
         out_count_ff <= '0;
         mv_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
         mv_pend_ff   <= mv_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (in_we) begin
         in_mem[in_waddr] <= in_wdata;
      end
      in_rd_ff <= in_mem[in_raddr];
   end

   always_ff @(posedge clock) begin
      if (out_we) begin
         out_mem[out_waddr] <= in_rd_ff;
      end
      out_rd_ff <= out_mem[out_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
